### hdl/sts_pkg.sv
// sts_pkg: shared types, codes and defaults for the sorted table search block.
// Used by every module in hdl/; depends on nothing.
`default_nettype none

package sts_pkg;

   // fixed field widths
   localparam int POS_WIDTH   = 11;
   localparam int INDEX_WIDTH = 10;
   localparam int REQ_WIDTH   = 32;
   localparam int CSR_WIDTH   = 32;
   localparam int ADDR_WIDTH  = 3;

   // parameter defaults
   localparam int DEPTH_DEF       = 1024;
   localparam int VALUE_WIDTH_DEF = 32;

   // request op codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // register select (paddr bit 2)
   localparam logic REG_COUNT = 1'b0;
   localparam logic REG_MODE  = 1'b1;

   typedef enum logic [1:0] {
      MODE_EXACT = 2'd0,
      MODE_LOWER = 2'd1,
      MODE_FIRST = 2'd2,
      MODE_LAST  = 2'd3
   } mode_type;

   // controller -> datapath
   typedef struct packed {
      logic start;     // latch target, count, mode; open interval
      logic write;     // store one table entry
      logic step;      // compare probe data, narrow interval
      logic out_load;  // capture result into output registers
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic more;      // interval non-empty and no early stop
   } status_type;

endpackage

`default_nettype wire

### hdl/sts_csr.sv
// sts_csr: APB-style register file holding entry_count and search_mode.
// Depends on sts_pkg.
`default_nettype none

module sts_csr
   import sts_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_WIDTH-1:0]  csr_pwdata,
   output logic      [CSR_WIDTH-1:0]  csr_prdata,
   output logic                       csr_pready,
   output logic      [POS_WIDTH-1:0]  entry_count,
   output mode_type                   search_mode
);

   logic [POS_WIDTH-1:0] count_ff, count_in;
   mode_type             mode_ff, mode_in;
   logic                 wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      count_in = count_ff;
      mode_in  = mode_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            REG_COUNT: count_in = csr_pwdata[POS_WIDTH-1:0];
            REG_MODE:  mode_in  = mode_type'(csr_pwdata[1:0]);
            default:   count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mode_ff  <= MODE_EXACT;
      end else begin
         count_ff <= count_in;
         mode_ff  <= mode_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_COUNT: csr_prdata = CSR_WIDTH'(count_ff);
         REG_MODE:  csr_prdata = CSR_WIDTH'(mode_ff);
         default:   csr_prdata = '0;
      endcase
   end

   assign entry_count = count_ff;
   assign search_mode = mode_ff;

endmodule

`default_nettype wire

### hdl/sts_datapath.sv
// sts_datapath: entry memory, search interval registers, probe compare and
// result registers. Driven by sts_ctrl through cmd_type; depends on sts_pkg.
`default_nettype none

module sts_datapath
   import sts_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
   input  wire logic                   clock,
   input  wire cmd_type                cmd,
   output status_type                  status,
   input  wire logic [INDEX_WIDTH-1:0] req_index,
   input  wire logic signed [REQ_WIDTH-1:0] req_value,
   input  wire logic [POS_WIDTH-1:0]   entry_count,
   input  wire mode_type               search_mode,
   output logic                        rsp_found,
   output logic      [POS_WIDTH-1:0]   rsp_position
);

   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CAP = (DEPTH < 2047) ? DEPTH : 2047;
   localparam logic [POS_WIDTH-1:0] CAP_V = POS_WIDTH'(CAP);

   logic signed [VALUE_WIDTH-1:0] mem [DEPTH];

   logic signed [VALUE_WIDTH-1:0] target_ff, rd_ff, value_cvt;
   logic [POS_WIDTH-1:0] left_ff, left_in, hi_ff, hi_in, hit_ff, hit_in, n_ff;
   logic                 hit_vld_ff, hit_vld_in, stop_ff, stop_in;
   mode_type             mode_ff;
   logic                 found_ff;
   logic [POS_WIDTH-1:0] pos_ff;

   logic [POS_WIDTH:0]   mid_sum;
   logic [POS_WIDTH-1:0] mid, mid_inc, n_sat;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic                 wr_ok;

   // sign-adjust the 32-bit request value to the table word width
   assign value_cvt = VALUE_WIDTH'(req_value);

   // floor midpoint: of left and hi-1 for match modes, of left and hi for lower bound
   assign mid_sum = {1'b0, left_ff} + {1'b0, hi_ff}
                    - ((mode_ff != MODE_LOWER) ? (POS_WIDTH+1)'(1) : '0);
   assign mid     = mid_sum[POS_WIDTH:1];
   assign mid_inc = mid + POS_WIDTH'(1);

   assign rd_addr = AW'(mid);
   assign wr_addr = AW'(req_index);
   assign wr_ok   = (32'(req_index) < 32'(DEPTH));
   assign n_sat   = (entry_count > CAP_V) ? CAP_V : entry_count;

   always_ff @(posedge clock) begin
      if (cmd.write && wr_ok) begin
         mem[wr_addr] <= value_cvt;
      end
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      left_in    = left_ff;
      hi_in      = hi_ff;
      hit_in     = hit_ff;
      hit_vld_in = hit_vld_ff;
      stop_in    = stop_ff;
      if (cmd.start) begin
         left_in    = '0;
         hi_in      = n_sat;
         hit_in     = '0;
         hit_vld_in = 1'b0;
         stop_in    = 1'b0;
      end else if (cmd.step) begin
         if (mode_ff == MODE_LOWER) begin
            if (rd_ff < target_ff) left_in = mid_inc;
            else                   hi_in   = mid;
         end else if (rd_ff == target_ff) begin
            hit_in     = mid;
            hit_vld_in = 1'b1;
            unique case (mode_ff)
               MODE_FIRST: hi_in   = mid;
               MODE_LAST:  left_in = mid_inc;
               default:    stop_in = 1'b1;
            endcase
         end else if (rd_ff < target_ff) begin
            left_in = mid_inc;
         end else begin
            hi_in = mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      left_ff    <= left_in;
      hi_ff      <= hi_in;
      hit_ff     <= hit_in;
      hit_vld_ff <= hit_vld_in;
      stop_ff    <= stop_in;
      if (cmd.start) begin
         target_ff <= value_cvt;
         n_ff      <= n_sat;
         mode_ff   <= search_mode;
      end
      if (cmd.out_load) begin
         if (mode_ff == MODE_LOWER) begin
            found_ff <= (left_ff < n_ff);
            pos_ff   <= left_ff;
         end else begin
            found_ff <= hit_vld_ff;
            pos_ff   <= hit_vld_ff ? hit_ff : '0;
         end
      end
   end

   assign status.more  = (left_ff < hi_ff) && !stop_ff;
   assign rsp_found    = found_ff;
   assign rsp_position = pos_ff;

endmodule

`default_nettype wire

### hdl/sts_ctrl.sv
// sts_ctrl: request/response handshake and probe sequencer for the search.
// Issues cmd_type to sts_datapath, reads status_type; depends on sts_pkg.
`default_nettype none

module sts_ctrl
   import sts_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_op,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output cmd_type         cmd,
   input  wire status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,   // take requests
      ST_ADDR,   // memory read at midpoint in flight
      ST_CMP,    // compare read data, narrow interval
      ST_DONE    // wait for output slot
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_take, slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_op == OP_QUERY) begin
                  cmd.start = 1'b1;
                  state_in  = ST_ADDR;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_ADDR: begin
            state_in = status.more ? ST_CMP : ST_DONE;
         end
         ST_CMP: begin
            cmd.step = 1'b1;
            state_in = ST_ADDR;
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### hdl/sorted_table_search.sv
// sorted_table_search: binary search over a sorted table of signed words.
// Write request: stored at the accept edge (if req_index < DEPTH), no response.
// Query: up to ceil(log2(n+1)) probes, each a memory read (ST_ADDR) then a compare
//   (ST_CMP), then the result is loaded in ST_DONE; requests are taken again only
//   back in ST_IDLE. A stalled response holds the next result back.
// Reset: controller idle, entry_count and search_mode 0; table contents undefined.
`default_nettype none

module sorted_table_search
   import sts_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_op,
   input  wire logic [INDEX_WIDTH-1:0] req_index,
   input  wire logic signed [REQ_WIDTH-1:0] req_value,
   // response channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_found,
   output logic      [POS_WIDTH-1:0]   rsp_position,
   // register port
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [CSR_WIDTH-1:0]   csr_pwdata,
   output logic      [CSR_WIDTH-1:0]   csr_prdata,
   output logic                        csr_pready
);

   cmd_type              cmd;
   status_type           status;
   logic [POS_WIDTH-1:0] entry_count;
   mode_type             search_mode;

   // registers: entry_count at 0x0, search_mode at 0x4
   sts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .entry_count (entry_count),
      .search_mode (search_mode)
   );

   // sequencer: one request at a time, probe loop of read + compare
   sts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // table memory, interval bounds, compare and result registers
   sts_datapath #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .status       (status),
      .req_index    (req_index),
      .req_value    (req_value),
      .entry_count  (entry_count),
      .search_mode  (search_mode),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position)
   );

endmodule

`default_nettype wire
